/* rtl/normal_difference_curvature_macros.svh */
// Assertion macros shared by the curvature RTL.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef NORMAL_DIFFERENCE_CURVATURE_MACROS_SVH
`define NORMAL_DIFFERENCE_CURVATURE_MACROS_SVH

// consequent must hold in the same cycle
`define NDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define NDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ndc_pkg.sv */
// Shared types and constants for the normal-difference curvature block.
// No dependencies.
package ndc_pkg;

    localparam int POS_W     = 32;
    localparam int NORM_W    = 16;
    localparam int DP_W      = 33;   // |position difference|, up to 2^32 - 1
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 48;
    localparam int QUEUE_DEPTH = 2;

    localparam logic KIND_CENTER   = 1'b0;
    localparam logic KIND_NEIGHBOR = 1'b1;

    localparam logic CFG_MIN_DISTANCE  = 1'b0;
    localparam logic CFG_COLOR_DIVISOR = 1'b1;

    localparam logic [15:0] MIN_DIST_RESET  = 16'd66;
    localparam logic [7:0]  COLOR_DIV_RESET = 8'd5;

    // one classified transaction handed from front to back
    typedef struct packed {
        logic                         kind;
        logic                         last;
        logic [2:0][DP_W-1:0]         dp;
        logic [2:0][NORM_W-1:0]       dn;
    } t_item;

endpackage

/* rtl/ndc_front.sv */
// Input side: accepts transactions, keeps the center vertex, forms absolute
// differences and queues classified items. Depends on ndc_pkg.
module ndc_front #(
    parameter int Depth = ndc_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ndc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,
    output ndc_pkg::t_item                 o_item,
    output logic                           o_item_valid,
    input  logic                           i_item_pop
);
    import ndc_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [2:0][POS_W-1:0]  r_cpos;
    logic [2:0][NORM_W-1:0] r_cnorm;
    t_item                  r_q [Depth];
    logic [PtrW-1:0]        r_wr, r_rd;
    logic [CntW-1:0]        r_cnt;

    t_item      n_entry;
    logic       v_push, v_pop;
    logic [POS_W:0]  v_dpos;
    logic [NORM_W:0] v_dnorm;

    assign s_axis_tready = (r_cnt != CntW'(Depth));
    assign o_item_valid  = (r_cnt != '0);
    assign o_item        = r_q[r_rd];
    assign v_push        = s_axis_tvalid && s_axis_tready;
    assign v_pop         = i_item_pop && o_item_valid;

    always_comb begin
        n_entry      = '0;
        v_dpos       = '0;
        v_dnorm      = '0;
        n_entry.kind = s_axis_tuser;
        n_entry.last = s_axis_tlast;
        for (int c = 0; c < 3; c++) begin
            v_dpos = {s_axis_tdata[POS_W*c + POS_W-1], s_axis_tdata[POS_W*c +: POS_W]}
                   - {r_cpos[c][POS_W-1], r_cpos[c]};
            n_entry.dp[c] = v_dpos[POS_W] ? (~v_dpos + 1'b1) : v_dpos;
            v_dnorm = {s_axis_tdata[96 + NORM_W*c + NORM_W-1],
                       s_axis_tdata[96 + NORM_W*c +: NORM_W]}
                    - {r_cnorm[c][NORM_W-1], r_cnorm[c]};
            n_entry.dn[c] = v_dnorm[NORM_W] ? NORM_W'(~v_dnorm + 1'b1)
                                            : v_dnorm[NORM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpos  <= '0;
            r_cnorm <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            if (v_push) begin
                r_q[r_wr] <= n_entry;
                r_wr      <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
                if (s_axis_tuser == KIND_CENTER) begin
                    for (int c = 0; c < 3; c++) begin
                        r_cpos[c]  <= s_axis_tdata[POS_W*c +: POS_W];
                        r_cnorm[c] <= s_axis_tdata[96 + NORM_W*c +: NORM_W];
                    end
                end
            end
            if (v_pop)
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            if (v_push && !v_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!v_push && v_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

/* rtl/ndc_back.sv */
// Execution side: squares on a shared 17x17 multiplier, bit-serial square
// root and restoring divider, curvature sum and result register.
// Depends on ndc_pkg and normal_difference_curvature_macros.svh.
`include "normal_difference_curvature_macros.svh"

module ndc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ndc_pkg::t_item                 i_item,
    input  logic                           i_item_valid,
    output logic                           o_item_pop,
    input  logic [15:0]                    i_min_distance,
    input  logic [7:0]                     i_color_divisor,
    output logic                           o_m_valid,
    input  logic                           i_m_ready,
    output logic [ndc_pkg::M_TDATA_W-1:0]  o_m_data,
    output logic                           o_m_user
);
    import ndc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_N, S_ROOT_LD, S_ROOT_D, S_ROOT_N, S_DIV_T,
        S_LAST, S_DIV_M, S_MUL_C, S_COLOR, S_DIV_C, S_OUT
    } t_state;

    localparam logic [1:0] PART_LL = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_HH = 2'd2;

    t_state                 r_state;
    logic [2:0][DP_W-1:0]   r_dp;
    logic [2:0][NORM_W-1:0] r_dn;
    logic                   r_last;
    logic [39:0]            r_sum;
    logic [2:0]             r_count;
    // multiplier pipe
    logic [3:0]             r_step;
    logic                   r_issued;
    logic                   r_pv;
    logic [33:0]            r_prod;
    logic                   r_ptgt;    // 1: normal / divisor accumulator
    logic [1:0]             r_psh;
    logic [65:0]            r_psq;
    logic [33:0]            r_nsq;
    // root and divider
    logic [5:0]             r_iter;
    logic [65:0]            r_rad;
    logic [33:0]            r_srem;
    logic [32:0]            r_root;
    logic [32:0]            r_dist;
    logic [47:0]            r_drem;
    logic [39:0]            r_dq;
    logic [47:0]            r_den;
    // result
    logic [31:0]            r_mean;
    logic [7:0]             r_q;
    logic                   r_res_valid;
    logic                   r_m_valid;
    logic [31:0]            r_m_mean;
    logic [7:0]             r_m_green;
    logic                   r_m_res;

    logic [32:0] v_src;
    logic [1:0]  v_part;
    logic        v_tgt;
    logic [16:0] v_a, v_b;
    logic [33:0] v_prod;
    logic [1:0]  v_sh;
    logic [7:0]  v_div;
    logic [65:0] v_addend;
    logic [35:0] v_rem2, v_trial, v_rsub;
    logic        v_rge;
    logic [48:0] v_dt, v_dsub;
    logic        v_dge;

    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign o_m_valid  = r_m_valid;
    // blue is 255 - green for a valid result, zero otherwise
    assign o_m_data   = {(r_m_res ? ~r_m_green : 8'd0), r_m_green, r_m_mean};
    assign o_m_user   = r_m_res;
    assign v_div      = (i_color_divisor == '0) ? 8'd1 : i_color_divisor;

    // operand schedule: three components as lo*lo, hi*lo, hi*hi, then the
    // normal squares, then mean squared and divisor squared
    always_comb begin
        v_tgt = 1'b0;
        unique case (r_step)
            4'd0:  begin v_src = r_dp[0];             v_part = PART_LL; end
            4'd1:  begin v_src = r_dp[0];             v_part = PART_HL; end
            4'd2:  begin v_src = r_dp[0];             v_part = PART_HH; end
            4'd3:  begin v_src = r_dp[1];             v_part = PART_LL; end
            4'd4:  begin v_src = r_dp[1];             v_part = PART_HL; end
            4'd5:  begin v_src = r_dp[1];             v_part = PART_HH; end
            4'd6:  begin v_src = r_dp[2];             v_part = PART_LL; end
            4'd7:  begin v_src = r_dp[2];             v_part = PART_HL; end
            4'd8:  begin v_src = r_dp[2];             v_part = PART_HH; end
            4'd9:  begin v_src = {17'd0, r_dn[0]};    v_part = PART_LL; v_tgt = 1'b1; end
            4'd10: begin v_src = {17'd0, r_dn[1]};    v_part = PART_LL; v_tgt = 1'b1; end
            4'd11: begin v_src = {17'd0, r_dn[2]};    v_part = PART_LL; v_tgt = 1'b1; end
            4'd12: begin v_src = {1'b0, r_mean};      v_part = PART_LL; end
            4'd13: begin v_src = {1'b0, r_mean};      v_part = PART_HL; end
            4'd14: begin v_src = {1'b0, r_mean};      v_part = PART_HH; end
            default: begin v_src = {25'd0, v_div};    v_part = PART_LL; v_tgt = 1'b1; end
        endcase
        unique case (v_part)
            PART_HL: begin v_a = v_src[32:16]; v_b = {1'b0, v_src[15:0]}; v_sh = PART_HL; end
            PART_HH: begin v_a = v_src[32:16]; v_b = v_src[32:16];         v_sh = PART_HH; end
            default: begin
                v_a = {1'b0, v_src[15:0]}; v_b = {1'b0, v_src[15:0]}; v_sh = PART_LL;
            end
        endcase
        v_prod = v_a * v_b;
    end

    always_comb begin
        unique case (r_psh)
            PART_HL: v_addend = {15'd0, r_prod, 17'd0};   // 2*hi*lo << 16
            PART_HH: v_addend = {r_prod, 32'd0};
            default: v_addend = {32'd0, r_prod};
        endcase
    end

    // one root digit and one quotient bit per cycle
    always_comb begin
        v_rem2  = {r_srem, r_rad[65:64]};
        v_trial = {1'b0, r_root, 2'b01};
        v_rsub  = v_rem2 - v_trial;
        v_rge   = (v_rem2 >= v_trial);
        v_dt    = {r_drem, r_dq[39]};
        v_dsub  = v_dt - {1'b0, r_den};
        v_dge   = (v_dt >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sum     <= '0;
            r_count   <= '0;
            r_pv      <= 1'b0;
            r_issued  <= 1'b0;
            r_iter    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && i_m_ready && r_state != S_OUT)
                r_m_valid <= 1'b0;

            if (r_state == S_MUL_N || r_state == S_MUL_C) begin
                if (r_pv) begin
                    if (r_ptgt)
                        r_nsq <= r_nsq + r_prod;
                    else
                        r_psq <= r_psq + v_addend;
                end
                if (!r_issued) begin
                    r_prod <= v_prod;
                    r_ptgt <= v_tgt;
                    r_psh  <= v_sh;
                    r_pv   <= 1'b1;
                    r_step <= r_step + 1'b1;
                    if (r_step == ((r_state == S_MUL_C) ? 4'd15 : 4'd11))
                        r_issued <= 1'b1;
                end else begin
                    r_pv    <= 1'b0;
                    r_state <= (r_state == S_MUL_C) ? S_COLOR : S_ROOT_LD;
                end
            end

            if ((r_state == S_ROOT_D || r_state == S_ROOT_N) && r_iter != '0) begin
                r_srem <= v_rge ? v_rsub[33:0] : v_rem2[33:0];
                r_root <= {r_root[31:0], v_rge};
                r_rad  <= {r_rad[63:0], 2'b00};
                r_iter <= r_iter - 1'b1;
            end
            if ((r_state == S_DIV_T || r_state == S_DIV_M || r_state == S_DIV_C)
                    && r_iter != '0) begin
                r_drem <= v_dge ? v_dsub[47:0] : v_dt[47:0];
                r_dq   <= {r_dq[38:0], v_dge};
                r_iter <= r_iter - 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        if (i_item.kind == KIND_CENTER) begin
                            r_sum   <= '0;
                            r_count <= '0;
                        end else begin
                            r_dp     <= i_item.dp;
                            r_dn     <= i_item.dn;
                            r_last   <= i_item.last;
                            r_psq    <= '0;
                            r_nsq    <= '0;
                            r_step   <= 4'd0;
                            r_issued <= 1'b0;
                            r_pv     <= 1'b0;
                            r_state  <= S_MUL_N;
                        end
                    end
                end
                S_MUL_N, S_MUL_C: ;
                S_ROOT_LD: begin
                    r_rad   <= r_psq;
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_iter  <= 6'd33;
                    r_state <= S_ROOT_D;
                end
                S_ROOT_D: begin
                    if (r_iter == '0) begin
                        r_dist <= r_root;
                        if (r_root > {17'd0, i_min_distance} && r_count != 3'd7) begin
                            // normal difference length: sqrt(nsq << 4)
                            r_rad   <= {r_nsq, 32'd0};
                            r_srem  <= '0;
                            r_root  <= '0;
                            r_iter  <= 6'd19;
                            r_state <= S_ROOT_N;
                        end else begin
                            r_state <= S_LAST;
                        end
                    end
                end
                S_ROOT_N: begin
                    if (r_iter == '0) begin
                        r_drem  <= '0;
                        r_dq    <= {r_root[18:0], 21'd0};
                        r_den   <= {15'd0, r_dist};
                        r_iter  <= 6'd35;
                        r_state <= S_DIV_T;
                    end
                end
                S_DIV_T: begin
                    if (r_iter == '0) begin
                        r_sum   <= r_sum + {5'd0, r_dq[34:0]};
                        r_count <= r_count + 1'b1;
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_count == '0) begin
                        r_mean      <= '0;
                        r_q         <= '0;
                        r_res_valid <= 1'b0;
                        r_state     <= S_OUT;
                    end else begin
                        r_res_valid <= 1'b1;
                        r_drem      <= '0;
                        r_dq        <= r_sum;
                        r_den       <= {45'd0, r_count};
                        r_iter      <= 6'd40;
                        r_state     <= S_DIV_M;
                    end
                end
                S_DIV_M: begin
                    if (r_iter == '0) begin
                        r_mean   <= (r_dq[39:32] != '0) ? '1 : r_dq[31:0];
                        r_psq    <= '0;
                        r_nsq    <= '0;
                        r_step   <= 4'd12;
                        r_issued <= 1'b0;
                        r_pv     <= 1'b0;
                        r_state  <= S_MUL_C;
                    end
                end
                S_COLOR: begin
                    // mean^2 against 256 * div^2 * 2^32 decides saturation
                    if (r_psq[63:0] >= {8'd0, r_nsq[15:0], 40'd0}) begin
                        r_q     <= 8'hFF;
                        r_state <= S_OUT;
                    end else begin
                        r_drem  <= r_psq[55:8];
                        r_dq    <= {r_psq[7:0], 32'd0};
                        r_den   <= {r_nsq[15:0], 32'd0};
                        r_iter  <= 6'd8;
                        r_state <= S_DIV_C;
                    end
                end
                S_DIV_C: begin
                    if (r_iter == '0) begin
                        r_q     <= r_dq[7:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_ready) begin
                        r_m_valid <= 1'b1;
                        r_m_mean  <= r_mean;
                        r_m_green <= r_q;
                        r_m_res   <= r_res_valid;
                        r_sum     <= '0;
                        r_count   <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `NDC_ASSERT_NOW(a_den_nonzero, (r_state == S_DIV_T || r_state == S_DIV_M || r_state == S_DIV_C) && (r_iter != 6'd0), r_den != 48'd0, "divider running with zero divisor")
    `NDC_ASSERT_NOW(a_count_cap, (r_state == S_DIV_T) && (r_iter == 6'd0), r_count != 3'd7, "term added past count limit")
    `NDC_ASSERT_NEXT(a_empty_last, (r_state == S_LAST) && r_last && (r_count == 3'd0), (r_state == S_OUT) && !r_res_valid, "last neighbor with no terms did not report invalid")

endmodule

/* rtl/normal_difference_curvature.sv */
// Top level of the normal-difference curvature block: configuration
// registers, front (queue) and back (arithmetic). Depends on ndc_pkg.
//
//  channel   direction  handshake              contents
//  s_axis    in         tvalid/tready          tdata pos/norm, tuser func, tlast last
//  m_axis    out        tvalid/tready          tdata mean/green/blue, tuser valid_res
//  cfg       in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// A center transaction only clears the running sum and count in the back end.
// A neighbor runs 12 multiplies on one 17x17 multiplier and a 33-step square
// root, then a 19-step root and a 35-step divide when its term is counted. A
// last neighbor with counted terms adds a 40-step mean divide, 4 multiplies
// and an 8-step color divide, the divide skipped when the color saturates.
// A stalled output holds the back end until the result register frees. The
// front queue holds two transactions so input and output stall independently;
// reset is synchronous and needs no clearing pass.
module normal_difference_curvature #(
    parameter int QueueDepth = ndc_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (lowest first)
    input  logic [ndc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // mean, green, blue (lowest first)
    output logic [ndc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // valid_res
    output logic                           m_axis_tuser,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [15:0]                    i_cfg_data
);
    import ndc_pkg::*;

    logic [15:0] r_min_distance;
    logic [7:0]  r_color_divisor;
    t_item       w_item;
    logic        w_item_valid;
    logic        w_item_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_distance  <= MIN_DIST_RESET;
            r_color_divisor <= COLOR_DIV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_DISTANCE:  r_min_distance  <= i_cfg_data;
                CFG_COLOR_DIVISOR: r_color_divisor <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ndc_front #(
        .Depth (QueueDepth)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_item_pop    (w_item_pop)
    );

    ndc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_item),
        .i_item_valid    (w_item_valid),
        .o_item_pop      (w_item_pop),
        .i_min_distance  (r_min_distance),
        .i_color_divisor (r_color_divisor),
        .o_m_valid       (m_axis_tvalid),
        .i_m_ready       (m_axis_tready),
        .o_m_data        (m_axis_tdata),
        .o_m_user        (m_axis_tuser)
    );

endmodule
